/* sv/rle8bd_pkg.sv */
package rle8bd_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_IMAGE_BYTES = 1'b0;
    localparam logic REG_LINE_BYTES  = 1'b1;

    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_END   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_VALUE,
        PH_LITERAL,
        PH_PAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_RUN,
        KIND_FILL
    } t_kind;

    typedef struct packed {
        logic       start;
        t_kind      kind;
        logic [7:0] value;
        logic [7:0] count;
        logic       done;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

/* sv/rle8bd_front.sv */
module rle8bd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_src_byte,
    input  logic                 i_src_last,
    input  logic                 i_image_start,
    input  logic                 i_image_zero,
    input  rle8bd_pkg::t_fifo_status i_status,
    output logic                 o_push,
    output rle8bd_pkg::t_cmd     o_cmd
);
    import rle8bd_pkg::*;

    t_phase     r_phase, n_phase, cur_phase;
    logic [7:0] r_held, n_held, cur_held;
    logic [7:0] r_lit, n_lit, cur_lit;
    logic       r_pad, n_pad, cur_pad;
    logic       r_fin, n_fin;
    logic       accept, active, skip;
    t_cmd       cmd;

    assign o_ready = !i_status.full;
    assign accept  = i_valid && !i_status.full;

    always_comb begin
        active    = i_image_start || !r_fin;
        skip      = i_image_start && i_image_zero;
        cur_phase = i_image_start ? PH_COUNT : r_phase;
        cur_held  = i_image_start ? 8'd0 : r_held;
        cur_lit   = i_image_start ? 8'd0 : r_lit;
        cur_pad   = i_image_start ? 1'b0 : r_pad;
        n_phase   = cur_phase;
        n_held    = cur_held;
        n_lit     = cur_lit;
        n_pad     = cur_pad;
        n_fin     = i_image_start ? skip : r_fin;
        cmd       = '0;
        cmd.kind  = KIND_NONE;
        cmd.start = i_image_start;
        cmd.value = i_src_byte;
        if (active && !skip) begin
            unique case (cur_phase)
                PH_COUNT: begin
                    n_held  = i_src_byte;
                    n_phase = PH_VALUE;
                end
                PH_VALUE: begin
                    n_phase = PH_COUNT;
                    if (cur_held != 8'd0) begin
                        cmd.kind  = KIND_RUN;
                        cmd.count = cur_held;
                    end else if (i_src_byte > ESC_DELTA) begin
                        n_lit   = i_src_byte;
                        n_pad   = i_src_byte[0];
                        n_phase = PH_LITERAL;
                    end else if (i_src_byte == ESC_EOL) begin
                        cmd.kind  = KIND_FILL;
                        cmd.value = 8'd0;
                    end else if (i_src_byte == ESC_END) begin
                        cmd.done = 1'b1;
                    end
                end
                PH_LITERAL: begin
                    cmd.kind  = KIND_RUN;
                    cmd.count = 8'd1;
                    n_lit     = cur_lit - 8'd1;
                    if (cur_lit == 8'd1) begin
                        n_phase = cur_pad ? PH_PAD : PH_COUNT;
                        n_pad   = 1'b0;
                    end
                end
                PH_PAD: begin
                    n_phase = PH_COUNT;
                end
            endcase
            if (i_src_last) begin
                cmd.done = 1'b1;
            end
            if (cmd.done) begin
                n_fin = 1'b1;
            end
        end
        o_cmd  = cmd;
        o_push = accept && (i_image_start || cmd.kind != KIND_NONE || cmd.done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
            r_held  <= '0;
            r_lit   <= '0;
            r_pad   <= 1'b0;
            r_fin   <= 1'b1;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_lit   <= n_lit;
            r_pad   <= n_pad;
            r_fin   <= n_fin;
        end
    end

endmodule

/* sv/rle8bd_fifo.sv */
module rle8bd_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  rle8bd_pkg::t_cmd              i_cmd,
    input  logic                          i_pop,
    output rle8bd_pkg::t_cmd              o_cmd,
    output rle8bd_pkg::t_fifo_status      o_status,
    output logic [rle8bd_pkg::FIFO_CW-1:0] o_count
);
    import rle8bd_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               do_push, do_pop;

    assign o_status.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

endmodule

/* sv/rle8bd_back.sv */
module rle8bd_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rle8bd_pkg::t_cmd         i_cmd,
    input  rle8bd_pkg::t_fifo_status i_status,
    output logic                     o_pop,
    input  logic [23:0]              i_image_bytes,
    input  logic [15:0]              i_line_bytes,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [7:0]               o_out_value,
    output logic [15:0]              o_run_length,
    output logic                     o_image_done
);
    import rle8bd_pkg::*;

    logic [23:0] r_output_left, n_output_left, base_left;
    logic [23:0] r_line_offset, n_line_offset, base_off;
    logic        r_fin, n_fin;
    logic        r_out_valid;
    logic [7:0]  r_out_value;
    logic [15:0] r_run_length;
    logic        r_image_done;
    logic        active, empty_start, fill_ok, emitted, done;
    logic [15:0] req, len;

    assign o_pop = !i_status.empty && (!r_out_valid || i_ready);

    always_comb begin
        base_left   = i_cmd.start ? i_image_bytes : r_output_left;
        base_off    = i_cmd.start ? 24'd0 : r_line_offset;
        active      = i_cmd.start || !r_fin;
        empty_start = i_cmd.start && (i_image_bytes == 24'd0);
        fill_ok     = {8'd0, i_line_bytes} > base_off;
        req         = (i_cmd.kind == KIND_FILL) ? (i_line_bytes - base_off[15:0])
                                                : {8'd0, i_cmd.count};
        len         = ({8'd0, req} > base_left) ? base_left[15:0] : req;
        emitted     = active && !empty_start
                      && (i_cmd.kind == KIND_RUN || (i_cmd.kind == KIND_FILL && fill_ok));
        n_output_left = emitted ? (base_left - {8'd0, len}) : base_left;
        if (i_cmd.kind == KIND_FILL) begin
            n_line_offset = 24'd0;
        end else if (emitted) begin
            n_line_offset = base_off + {8'd0, len};
        end else begin
            n_line_offset = base_off;
        end
        done  = active && (empty_start || i_cmd.done
                           || (emitted && n_output_left == 24'd0));
        n_fin = i_cmd.start ? 1'b0 : r_fin;
        if (done) begin
            n_fin = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_left <= '0;
            r_line_offset <= '0;
            r_fin         <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop && active) begin
                r_output_left <= n_output_left;
                r_line_offset <= n_line_offset;
                r_fin         <= n_fin;
            end
            if (o_pop && (emitted || done)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (emitted || done)) begin
            r_out_value  <= emitted ? i_cmd.value : 8'd0;
            r_run_length <= emitted ? len : 16'd0;
            r_image_done <= done;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_run_length = r_run_length;
    assign o_image_done = r_image_done;

endmodule

/* sv/rle8_bitmap_decoder.sv */
// RLE8 bitmap decoder. Takes one compressed byte per beat and sustains one byte
// per clock while the command queue is not full; each run, literal byte or line
// fill comes out as one result beat (value, run length, done flag), also one per
// clock while the sink is ready. A four-entry command queue between the byte
// parser and the run unit lets either side stall alone; a byte's command is
// written into the queue, and the run unit registers its result beat. Registers:
// image_bytes at 0x0 (taken at image start), line_bytes at 0x4 (used live by
// end-of-line fill). Write them only while the decoder is idle.
module rle8_bitmap_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_src_byte,
    input  logic        i_src_last,
    input  logic        i_image_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_value,
    output logic [15:0] o_run_length,
    output logic        o_image_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [rle8bd_pkg::APB_AW-1:0] paddr,
    input  logic [rle8bd_pkg::APB_DW-1:0] pwdata,
    output logic [rle8bd_pkg::APB_DW-1:0] prdata,
    output logic        pready
);
    import rle8bd_pkg::*;

    logic [23:0]        r_image_bytes;
    logic [15:0]        r_line_bytes;
    logic               cfg_wr;
    logic               push, pop;
    t_cmd               push_cmd, head_cmd;
    t_fifo_status       status;
    logic [FIFO_CW-1:0] fifo_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_bytes <= '0;
            r_line_bytes  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IMAGE_BYTES: r_image_bytes <= pwdata[23:0];
                REG_LINE_BYTES:  r_line_bytes  <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_BYTES: prdata = {8'd0, r_image_bytes};
            REG_LINE_BYTES:  prdata = {16'd0, r_line_bytes};
        endcase
    end

    rle8bd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_src_byte    (i_src_byte),
        .i_src_last    (i_src_last),
        .i_image_start (i_image_start),
        .i_image_zero  (r_image_bytes == 24'd0),
        .i_status      (status),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    rle8bd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (status),
        .o_count  (fifo_count)
    );

    rle8bd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_status      (status),
        .o_pop         (pop),
        .i_image_bytes (r_image_bytes),
        .i_line_bytes  (r_line_bytes),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_value   (o_out_value),
        .o_run_length  (o_run_length),
        .o_image_done  (o_image_done)
    );

    a_bare_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_run_length == 16'd0 |-> o_image_done)
        else $error("zero-length beat without done");

    a_long_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_run_length > 16'd255 |-> o_out_value == 8'd0)
        else $error("run longer than a count byte that is not a line fill");

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("command queue count out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> fifo_count != '0)
        else $error("run unit took a command from an empty queue");

endmodule
